// File: design/qat_pkg.sv
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and constants for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qat_pkg;

  localparam int unsigned CharW   = 16;
  localparam int unsigned StartW  = 13;
  localparam int unsigned TokW    = 9;
  localparam int unsigned PidxW   = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CharW-1:0] QuoteCode = 16'h0022;
  localparam logic [CharW-1:0] ParenCode = 16'h0028;
  localparam logic [TokW-1:0]  TokenMax  = 9'd511;

  // register reset values
  localparam logic [CharW-1:0] DelimAReset = 16'd32;
  localparam logic [CharW-1:0] DelimBReset = 16'd9;
  localparam logic [CharW-1:0] DelimCReset = 16'd44;
  localparam logic [CharW-1:0] DelimDReset = 16'd61;
  localparam logic [CharW-1:0] DelimEReset = 16'd59;

  typedef enum logic [CfgIdxW-1:0] {
    RegParamIndex   = 3'd0,
    RegRawMode      = 3'd1,
    RegWholeCmdline = 3'd2,
    RegDelimA       = 3'd3,
    RegDelimB       = 3'd4,
    RegDelimC       = 3'd5,
    RegDelimD       = 3'd6,
    RegDelimE       = 3'd7
  } qat_reg_e;

  typedef struct packed {
    logic [PidxW-1:0] param_index;
    logic             raw_mode;
    logic             whole_cmdline;
    logic [CharW-1:0] delim_a;
    logic [CharW-1:0] delim_b;
    logic [CharW-1:0] delim_c;
    logic [CharW-1:0] delim_d;
    logic [CharW-1:0] delim_e;
  } qat_cfg_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             end_marker;
  } qat_in_t;

  typedef struct packed {
    logic [CharW-1:0]  out_char;
    logic              found;
    logic [StartW-1:0] start_index;
    logic              is_summary;
  } qat_out_t;

  typedef struct packed {
    logic in_token;
    logic in_quote;
    logic finished;
  } qat_flags_t;

endpackage

`default_nettype wire

// File: design/qat_cfg_regs.sv
// ----------------------------------------------------------------------------
// qat_cfg_regs
// Configuration register file, written one register per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qat_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [qat_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [qat_pkg::CharW-1:0]     cfg_data_i,
  output qat_pkg::qat_cfg_t                  cfg_o
);

  qat_pkg::qat_cfg_t cfg_q;
  qat_pkg::qat_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (qat_pkg::qat_reg_e'(cfg_index_i))
        qat_pkg::RegParamIndex:   cfg_d.param_index   = cfg_data_i[qat_pkg::PidxW-1:0];
        qat_pkg::RegRawMode:      cfg_d.raw_mode      = cfg_data_i[0];
        qat_pkg::RegWholeCmdline: cfg_d.whole_cmdline = cfg_data_i[0];
        qat_pkg::RegDelimA:       cfg_d.delim_a       = cfg_data_i;
        qat_pkg::RegDelimB:       cfg_d.delim_b       = cfg_data_i;
        qat_pkg::RegDelimC:       cfg_d.delim_c       = cfg_data_i;
        qat_pkg::RegDelimD:       cfg_d.delim_d       = cfg_data_i;
        qat_pkg::RegDelimE:       cfg_d.delim_e       = cfg_data_i;
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.param_index   <= '0;
      cfg_q.raw_mode      <= 1'b0;
      cfg_q.whole_cmdline <= 1'b0;
      cfg_q.delim_a       <= qat_pkg::DelimAReset;
      cfg_q.delim_b       <= qat_pkg::DelimBReset;
      cfg_q.delim_c       <= qat_pkg::DelimCReset;
      cfg_q.delim_d       <= qat_pkg::DelimDReset;
      cfg_q.delim_e       <= qat_pkg::DelimEReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: design/qat_scan_step.sv
// ----------------------------------------------------------------------------
// qat_scan_step
// Next-state and result logic for one character of the scan.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qat_scan_step #(
  parameter int unsigned MAX_CHARS = 8192
) (
  input  wire qat_pkg::qat_cfg_t                  cfg_i,
  input  wire qat_pkg::qat_in_t                   item_i,
  input  wire qat_pkg::qat_flags_t                flags_i,
  input  wire logic [qat_pkg::TokW-1:0]           token_count_i,
  input  wire logic [$clog2(MAX_CHARS)-1:0]       position_i,
  input  wire logic [$clog2(MAX_CHARS)-1:0]       saved_start_i,
  output qat_pkg::qat_flags_t                     flags_o,
  output logic [qat_pkg::TokW-1:0]                token_count_o,
  output logic [$clog2(MAX_CHARS)-1:0]            position_o,
  output logic [$clog2(MAX_CHARS)-1:0]            saved_start_o,
  output logic                                    res_valid_o,
  output qat_pkg::qat_out_t                       res_o
);

  localparam int unsigned PosW = $clog2(MAX_CHARS);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_CHARS - 1);

  logic [qat_pkg::CharW-1:0] c;
  logic                      is_quote;
  logic                      is_delim;
  logic                      sel_cur;
  logic                      sel_one;
  logic                      keep_char;
  logic                      paren_split;
  logic [qat_pkg::TokW-1:0]  tc_inc;
  logic [PosW-1:0]           pos_inc;
  logic [PosW-1:0]           start_now;
  logic [31:0]               saved_wide;
  logic [31:0]               start_now_wide;

  assign c        = item_i.char_code;
  assign is_quote = (c == qat_pkg::QuoteCode);
  assign is_delim = (c == cfg_i.delim_a) || (c == cfg_i.delim_b) || (c == cfg_i.delim_c) ||
                    (c == cfg_i.delim_d) || (c == cfg_i.delim_e);
  assign sel_cur  = (token_count_i == {1'b0, cfg_i.param_index});
  assign sel_one  = ({1'b0, cfg_i.param_index} == 9'd1);
  // quotes are dropped unless raw mode is on
  assign keep_char   = !(is_quote && !cfg_i.raw_mode);
  assign paren_split = cfg_i.whole_cmdline && (token_count_i == '0) &&
                       (c == qat_pkg::ParenCode);
  assign tc_inc  = (token_count_i == qat_pkg::TokenMax) ? token_count_i
                                                         : token_count_i + 9'd1;
  assign pos_inc = (position_i < PosMax) ? position_i + PosW'(1) : position_i;
  // start of the current parameter once this character has been seen
  assign start_now      = flags_i.in_token ? saved_start_i : position_i;
  assign saved_wide     = 32'(saved_start_i);
  assign start_now_wide = 32'(start_now);

  always_comb begin
    flags_o       = flags_i;
    token_count_o = token_count_i;
    position_o    = position_i;
    saved_start_o = saved_start_i;
    res_valid_o   = 1'b0;
    res_o         = '0;
    if (item_i.end_marker) begin
      res_valid_o      = !flags_i.finished;
      res_o.is_summary = 1'b1;
      if (flags_i.in_token && sel_cur) begin
        res_o.found       = 1'b1;
        res_o.start_index = saved_wide[qat_pkg::StartW-1:0];
      end
      flags_o       = '0;
      token_count_o = '0;
      position_o    = '0;
      saved_start_o = '0;
    end else if (!flags_i.finished) begin
      position_o = pos_inc;
      if (flags_i.in_token && flags_i.in_quote) begin
        // quoted stretch: delimiters pass through
        if (is_quote) begin
          flags_o.in_quote = 1'b0;
        end
        res_valid_o    = sel_cur && keep_char;
        res_o.out_char = c;
      end else if (is_delim) begin
        if (flags_i.in_token) begin
          flags_o.in_token = 1'b0;
          flags_o.in_quote = 1'b0;
          if (sel_cur) begin
            flags_o.finished  = 1'b1;
            res_valid_o       = 1'b1;
            res_o.is_summary  = 1'b1;
            res_o.found       = 1'b1;
            res_o.start_index = saved_wide[qat_pkg::StartW-1:0];
          end else begin
            token_count_o = tc_inc;
          end
        end
      end else begin
        flags_o.in_token = 1'b1;
        if (!flags_i.in_token) begin
          flags_o.in_quote = 1'b0;
          saved_start_o    = position_i;
        end
        if (paren_split) begin
          // open parenthesis closes parameter zero and opens parameter one
          if (sel_cur) begin
            flags_o.in_token  = 1'b0;
            flags_o.in_quote  = 1'b0;
            flags_o.finished  = 1'b1;
            res_valid_o       = 1'b1;
            res_o.is_summary  = 1'b1;
            res_o.found       = 1'b1;
            res_o.start_index = start_now_wide[qat_pkg::StartW-1:0];
          end else begin
            token_count_o    = 9'd1;
            saved_start_o    = position_i;
            flags_o.in_quote = 1'b0;
            res_valid_o      = sel_one;
            res_o.out_char   = c;
          end
        end else begin
          if (is_quote) begin
            flags_o.in_quote = 1'b1;
          end
          res_valid_o    = sel_cur && keep_char;
          res_o.out_char = c;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: design/qat_out_buf.sv
// ----------------------------------------------------------------------------
// qat_out_buf
// Result register with a skid stage; stall to the producer is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qat_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire qat_pkg::qat_out_t  push_data_i,
  output logic                    full_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output qat_pkg::qat_out_t       out_data_o
);

  logic              main_v_q, main_v_d;
  logic              skid_v_q, skid_v_d;
  qat_pkg::qat_out_t main_q, main_d;
  qat_pkg::qat_out_t skid_q, skid_d;
  logic              pop;

  assign pop = main_v_q && !out_stall_i;

  always_comb begin
    main_v_d = main_v_q;
    skid_v_d = skid_v_q;
    main_d   = main_q;
    skid_d   = skid_q;
    if (skid_v_q) begin
      // producer is stalled while the skid holds an item
      if (pop) begin
        main_d   = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_q || pop) begin
        main_d   = push_data_i;
        main_v_d = 1'b1;
      end else begin
        skid_d   = push_data_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      main_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      main_v_q <= main_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_q <= main_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_v_q;
  assign out_valid_o = main_v_q;
  assign out_data_o  = main_q;

endmodule

`default_nettype wire

// File: design/quoted_argument_tokenizer.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Splits a command line, one character per item, into delimited parameters
// and streams out the selected one, followed by a summary item.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   -------  ---------  -------------------  ------------------------------
//   in       sink       in_valid/in_stall    char_code, end_marker
//   out      source     out_valid/out_stall  out_char, found, start_index,
//                                            is_summary
//   cfg      sink       cfg_valid/cfg_ready  register index, write data
//
// One character item is taken per cycle while in_stall_o is low; its result
// (if any) goes to the output register, or to the skid stage when that
// register is held. Both sit behind the combinational scan logic.
// in_stall_o rises only when the output register and its skid stage are
// both full, so a stalled output stops the input once the skid has filled.
// Reset clears the scan state and loads the register defaults; there is
// no clearing pass. cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quoted_argument_tokenizer #(
  parameter int unsigned MAX_CHARS = 8192
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // character items in
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire qat_pkg::qat_in_t             in_data_i,
  // result items out
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output qat_pkg::qat_out_t                 out_data_o,
  // register writes
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [qat_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [qat_pkg::CharW-1:0]    cfg_data_i
);

  // position counter is wide enough for MAX_CHARS-1, where it saturates
  localparam int unsigned PosW = $clog2(MAX_CHARS);

  qat_pkg::qat_cfg_t   cfg;
  qat_pkg::qat_flags_t flags_q, flags_d;
  logic [qat_pkg::TokW-1:0] token_count_q, token_count_d;
  logic [PosW-1:0]     position_q, position_d;
  logic [PosW-1:0]     saved_start_q, saved_start_d;
  logic                res_valid;
  qat_pkg::qat_out_t   res;
  logic                accept;
  logic                buf_full;

  assign cfg_ready_o = 1'b1;

  qat_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // an item is taken whenever the skid stage has room
  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  qat_scan_step #(
    .MAX_CHARS (MAX_CHARS)
  ) u_step (
    .cfg_i         (cfg),
    .item_i        (in_data_i),
    .flags_i       (flags_q),
    .token_count_i (token_count_q),
    .position_i    (position_q),
    .saved_start_i (saved_start_q),
    .flags_o       (flags_d),
    .token_count_o (token_count_d),
    .position_o    (position_d),
    .saved_start_o (saved_start_d),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // scan state advances only on an accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q       <= '0;
      token_count_q <= '0;
      position_q    <= '0;
      saved_start_q <= '0;
    end else if (accept) begin
      flags_q       <= flags_d;
      token_count_q <= token_count_d;
      position_q    <= position_d;
      saved_start_q <= saved_start_d;
    end
  end

  qat_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: tb/quoted_argument_tokenizer_test.sv
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer_test
// Self-checking bench for the quoted argument tokenizer. Command-line strings
// are queued as character items and fed through the in channel. A behavioural
// splitter inside the bench predicts each emitted character and summary item,
// and every item on the out channel is checked against the oldest
// prediction. Registers are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module quoted_argument_tokenizer_test;

  import qat_pkg::*;

  localparam int unsigned MaxChars = 8192;
  localparam logic [StartW-1:0] LastPos = StartW'(MaxChars - 1);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  qat_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  qat_out_t            out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CharW-1:0]    cfg_data_i = '0;

  quoted_argument_tokenizer #(
    .MAX_CHARS(MaxChars)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  qat_in_t  char_queue[$];     // items waiting to be offered to the block
  qat_out_t expected_out[$];   // predicted result items, oldest first
  int       mismatches = 0;
  int       queued;            // items queued in the current phase
  int       idle_pct;          // chance per cycle that the sender holds off
  int       stall_pct;         // chance per cycle that the receiver stalls

  // Shadow of the register file, loaded with the reset values
  qat_cfg_t cfg = '{param_index: '0, raw_mode: 1'b0, whole_cmdline: 1'b0,
                    delim_a: DelimAReset, delim_b: DelimBReset,
                    delim_c: DelimCReset, delim_d: DelimDReset,
                    delim_e: DelimEReset};

  // Shadow of the scan state
  logic [StartW-1:0] pos       = '0;
  logic [TokW-1:0]   tok_cnt   = '0;
  logic [StartW-1:0] start_pos = '0;
  logic              in_tok    = 1'b0;
  logic              in_qt     = 1'b0;
  logic              done      = 1'b0;

  // --------------------------------------------------------------------------
  // Splitter prediction
  // --------------------------------------------------------------------------
  function automatic bit is_delim(logic [CharW-1:0] c);
    return c == cfg.delim_a || c == cfg.delim_b || c == cfg.delim_c ||
           c == cfg.delim_d || c == cfg.delim_e;
  endfunction

  // Character of the selected parameter; quotes dropped unless raw
  function automatic void emit_char(logic [CharW-1:0] c);
    qat_out_t r;
    r = '0;
    r.out_char = c;
    if (tok_cnt == cfg.param_index && (cfg.raw_mode || c != QuoteCode))
      expected_out.push_back(r);
  endfunction

  // Closes the current parameter; 1 when it was the selected one
  function automatic bit close_param();
    qat_out_t r;
    in_tok = 1'b0;
    in_qt  = 1'b0;
    if (tok_cnt == cfg.param_index) begin
      done = 1'b1;
      r = '0;
      r.found       = 1'b1;
      r.start_index = start_pos;
      r.is_summary  = 1'b1;
      expected_out.push_back(r);
      return 1'b1;
    end
    if (tok_cnt != TokenMax) tok_cnt++;
    return 1'b0;
  endfunction

  function automatic void split_char(qat_in_t it);
    qat_out_t          r;
    logic [CharW-1:0]  c;
    logic [StartW-1:0] here;
    c = it.char_code;
    if (it.end_marker) begin
      if (!done) begin
        r = '0;
        r.is_summary = 1'b1;
        if (in_tok && tok_cnt == cfg.param_index) begin
          r.found       = 1'b1;
          r.start_index = start_pos;
        end
        expected_out.push_back(r);
      end
      pos = '0; tok_cnt = '0; start_pos = '0;
      in_tok = 1'b0; in_qt = 1'b0; done = 1'b0;
      return;
    end
    if (done) return;
    here = pos;
    if (pos != LastPos) pos++;
    // inside quotes nothing splits; a quote closes the stretch
    if (in_tok && in_qt) begin
      if (c == QuoteCode) in_qt = 1'b0;
      emit_char(c);
      return;
    end
    if (!in_tok) begin
      if (is_delim(c)) return;
      in_tok    = 1'b1;
      in_qt     = 1'b0;
      start_pos = here;
    end else if (is_delim(c)) begin
      void'(close_param());
      return;
    end
    // whole-command-line mode: '(' ends parameter zero and opens parameter one
    if (cfg.whole_cmdline && tok_cnt == 0 && c == ParenCode) begin
      if (close_param()) return;
      in_tok    = 1'b1;
      start_pos = here;
    end
    if (c == QuoteCode) in_qt = 1'b1;
    emit_char(c);
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offers queued items, predicts each one as it is taken
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : char_feed
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) split_char(in_data_i);
      // a new item may only be presented once the current one is gone
      if (!in_valid_i || !in_stall_o) begin
        if (char_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= char_queue.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    qat_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_out.size() == 0) begin
        $display("%0t ns: unexpected item: expected none, got char=%h found=%b start=%0d summary=%b",
                 $time, out_data_o.out_char, out_data_o.found,
                 out_data_o.start_index, out_data_o.is_summary);
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (out_data_o.out_char !== want.out_char || out_data_o.found !== want.found ||
            out_data_o.start_index !== want.start_index ||
            out_data_o.is_summary !== want.is_summary) begin
          $display("%0t ns: expected char=%h found=%b start=%0d summary=%b", $time,
                   want.out_char, want.found, want.start_index, want.is_summary);
          $display("%0t ns:      got char=%h found=%b start=%0d summary=%b", $time,
                   out_data_o.out_char, out_data_o.found, out_data_o.start_index,
                   out_data_o.is_summary);
          mismatches++;
        end
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_item(logic endm, logic [CharW-1:0] c);
    qat_in_t it;
    it.end_marker = endm;
    it.char_code  = c;
    char_queue.push_back(it);
    queued++;
  endtask

  function automatic logic [CharW-1:0] pick_delim();
    case ($urandom_range(4))
      0:       return cfg.delim_a;
      1:       return cfg.delim_b;
      2:       return cfg.delim_c;
      3:       return cfg.delim_d;
      default: return cfg.delim_e;
    endcase
  endfunction

  // a letter that neither splits nor quotes nor opens a bracket
  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    c = CharW'(16'h61 + $urandom_range(25));
    while (is_delim(c) || c == QuoteCode || c == ParenCode)
      c = CharW'(16'h61 + $urandom_range(25));
    return c;
  endfunction

  function automatic logic [CharW-1:0] rand_char();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return CharW'(16'h61 + $urandom_range(25));
    if (roll < 65) return QuoteCode;
    if (roll < 73) return ParenCode;
    if (roll < 83) return pick_delim();
    return CharW'($urandom);
  endfunction

  function automatic logic [CharW-1:0] rand_delim_code();
    case ($urandom_range(9))
      0:       return 16'd32;
      1:       return 16'd9;
      2:       return 16'd44;
      3:       return 16'd61;
      4:       return 16'd59;
      5:       return QuoteCode;
      6:       return ParenCode;
      7:       return 16'h0000;
      8:       return 16'hFFFF;
      default: return CharW'($urandom);
    endcase
  endfunction

  // Well-formed string: delimiter runs between parameters, random content,
  // closed by an end marker whose character field is noise
  task automatic gen_string(int ntok);
    for (int t = 0; t < ntok; t++) begin
      repeat ($urandom_range(t == 0 ? 0 : 1, t == 0 ? 1 : 3)) push_item(1'b0, pick_delim());
      repeat ($urandom_range(1, 6)) push_item(1'b0, rand_char());
    end
    if ($urandom_range(1)) push_item(1'b0, pick_delim());
    push_item(1'b1, CharW'($urandom));
  endtask

  task automatic write_reg(qat_reg_e idx, logic [CharW-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegParamIndex:   cfg.param_index   = val[PidxW-1:0];
      RegRawMode:      cfg.raw_mode      = val[0];
      RegWholeCmdline: cfg.whole_cmdline = val[0];
      RegDelimA:       cfg.delim_a       = val;
      RegDelimB:       cfg.delim_b       = val;
      RegDelimC:       cfg.delim_c       = val;
      RegDelimD:       cfg.delim_d       = val;
      RegDelimE:       cfg.delim_e       = val;
      default: ;
    endcase
  endtask

  // Waits until everything queued has been taken and answered, then allows
  // for an item still in flight that produces nothing
  task automatic settle();
    while (char_queue.size() != 0 || in_valid_i || expected_out.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_pressure(int ph);
    if (ph < 4) begin
      idle_pct  = 33;
      stall_pct = 78;
    end else if (ph < 8) begin
      idle_pct  = 78;
      stall_pct = 33;
    end else begin
      idle_pct  = 0;
      stall_pct = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin : sequencer
    logic [CharW-1:0] word;
    set_pressure(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset registers: field extremes, split at a delimiter,
    // characters after the summary, end marker after the summary
    push_item(1'b0, 16'h0000);
    push_item(1'b0, 16'h0061);
    push_item(1'b0, 16'hFFFF);
    push_item(1'b0, 16'd32);
    push_item(1'b0, 16'h0078);
    push_item(1'b1, 16'hFFFF);
    // leading delimiter, quote left open when the string ends
    push_item(1'b0, 16'd32);
    push_item(1'b0, QuoteCode);
    push_item(1'b0, 16'h0061);
    push_item(1'b0, 16'd32);
    push_item(1'b1, 16'h0000);
    // empty string
    push_item(1'b1, 16'h1234);
    settle();

    // Second parameter, raw quotes, whole-command-line mode; upper data bits set
    write_reg(RegParamIndex, 16'hA501);
    write_reg(RegRawMode, 16'h0001);
    write_reg(RegWholeCmdline, 16'hFFFF);
    // open a quoted stretch in parameter one, then stop mid-string
    push_item(1'b0, 16'h0078);
    push_item(1'b0, 16'd32);
    push_item(1'b0, QuoteCode);
    push_item(1'b0, 16'h0079);
    settle();

    // the quote becomes a delimiter mid-string: inside quotes it only closes
    write_reg(RegDelimE, QuoteCode);
    push_item(1'b0, QuoteCode);
    push_item(1'b0, 16'd32);
    push_item(1'b1, 16'h0000);
    // '(' as first character: empty parameter zero, parameter one from '('
    // and then a quote outside quotes splits
    push_item(1'b0, ParenCode);
    push_item(1'b0, 16'h0061);
    push_item(1'b0, QuoteCode);
    push_item(1'b0, 16'h0062);
    push_item(1'b1, 16'h0000);
    settle();

    // Random phases
    for (int ph = 0; ph < 12; ph++) begin
      set_pressure(ph);
      queued = 0;
      if (ph == 5) begin
        // highest parameter index: a string with enough parameters to reach it
        word = CharW'($urandom);
        word[PidxW-1:0] = 8'd255;
        write_reg(RegParamIndex, word);
        for (int t = 0; t < 257; t++) begin
          if (t != 0) push_item(1'b0, pick_delim());
          push_item(1'b0, plain_char());
        end
        push_item(1'b1, CharW'($urandom));
      end else begin
        word = CharW'($urandom);
        word[PidxW-1:0] = ($urandom_range(9) == 0) ? 8'd255 : PidxW'($urandom_range(4));
        write_reg(RegParamIndex, word);
        write_reg(RegRawMode, CharW'($urandom));
        write_reg(RegWholeCmdline, CharW'($urandom));
        write_reg(RegDelimA, (ph == 0) ? 16'h0000 : rand_delim_code());
        write_reg(RegDelimB, (ph == 1) ? 16'hFFFF : rand_delim_code());
        write_reg(RegDelimC, rand_delim_code());
        write_reg(RegDelimD, rand_delim_code());
        write_reg(RegDelimE, rand_delim_code());
        while (queued < 100) begin
          if ($urandom_range(9) == 0) begin
            // noise: arbitrary characters with stray end markers
            repeat ($urandom_range(1, 10))
              push_item($urandom_range(7) == 0, CharW'($urandom));
          end else begin
            gen_string($urandom_range(0, 6));
          end
        end
        // sometimes leave a string open across the next register update
        if ($urandom_range(3) == 0)
          repeat ($urandom_range(1, 5)) push_item(1'b0, rand_char());
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
